>>> rtl/crc32zs_pkg.sv
// Package with the shared types, constants and CRC step functions of the CRC-32 stream unit.
package crc32zs_pkg;

  localparam logic [31:0] POLY_RESET     = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES       = 32'hFFFFFFFF;
  localparam logic [31:0] X_POW_0        = 32'h80000000;
  localparam logic [31:0] X_POW_8        = 32'h00800000;
  localparam logic [7:0]  BYTE_ONES      = 8'hFF;
  localparam logic [7:0]  BYTE_ZERO      = 8'h00;
  localparam logic [2:0]  BYTES_SAT      = 3'd4;
  localparam logic [4:0]  MUL_STEP_LAST  = 5'd31;
  localparam logic [1:0]  PAD_STEP_LAST  = 2'd3;
  localparam logic        CMD_SHIFT      = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_SQR  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  typedef struct packed {
    logic       data_step;
    logic       shift_load;
    logic       pad_step;
    logic       mul_step;
    logic       mul_fin;
    logic       sqr_commit;
    logic       fin_commit;
    logic       out_load;
    logic       out_final;
    logic [4:0] mul_idx;
    logic [1:0] pad_idx;
  } ctrl_t;

  typedef struct packed {
    logic is_shift;
    logic is_last;
    logic count_zero;
    logic rest_zero;
  } status_t;

  // One byte of reflected division: reduce the low byte, shift the new byte in at the top.
  function automatic logic [31:0] div_step(input logic [31:0] crc, input logic [7:0] din,
                                           input logic [31:0] poly);
    logic [31:0] t;
    t = {24'd0, crc[7:0]};
    for (int k = 0; k < 8; k++) begin
      t = (t >> 1) ^ (t[0] ? poly : 32'd0);
    end
    return {din, crc[31:8]} ^ t;
  endfunction

  // One bit of a reflected GF(2) product modulo the polynomial.
  function automatic logic [31:0] gf_step(input logic [31:0] acc, input logic [31:0] a,
                                          input logic bit_b, input logic do_shift,
                                          input logic [31:0] poly);
    logic [31:0] t;
    t = acc ^ (bit_b ? a : 32'd0);
    if (do_shift) begin
      t = (t >> 1) ^ (t[0] ? poly : 32'd0);
    end
    return t;
  endfunction

endpackage

>>> rtl/crc32zs_in_if.sv
// Input channel interface carrying one command item per transfer.
interface crc32zs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic        first;
  logic        last;
  logic [31:0] zero_count;

  modport source (output valid, cmd, data_byte, first, last, zero_count, input ready);
  modport sink (input valid, cmd, data_byte, first, last, zero_count, output ready);
endinterface

>>> rtl/crc32zs_out_if.sv
// Output channel interface carrying one CRC result per transfer.
interface crc32zs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;
  logic        final_res;

  modport source (output valid, crc_value, final_res, input ready);
  modport sink (input valid, crc_value, final_res, output ready);
endinterface

>>> rtl/crc32zs_ctrl.sv
// Controller state machine sequencing byte steps, padding and the serial GF(2) multiplies.
module crc32zs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  crc32zs_pkg::status_t st,
  output crc32zs_pkg::ctrl_t   ctl
);

  crc32zs_pkg::state_t state;
  crc32zs_pkg::state_t state_next;
  logic [4:0] idx;
  logic [4:0] idx_next;
  logic [1:0] pad_idx;
  logic [1:0] pad_idx_next;
  logic       out_valid_next;
  logic       accept;
  logic       idx_end;
  logic       pad_end;

  assign in_ready = (state == crc32zs_pkg::S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_ready && in_valid;
  assign idx_end  = (idx == crc32zs_pkg::MUL_STEP_LAST);
  assign pad_end  = (pad_idx == crc32zs_pkg::PAD_STEP_LAST);

  always_comb begin
    ctl            = '0;
    ctl.mul_idx    = idx;
    ctl.pad_idx    = pad_idx;
    state_next     = state;
    case (state)
      crc32zs_pkg::S_IDLE: begin
        if (accept) begin
          if (st.is_shift) begin
            ctl.shift_load = 1'b1;
            state_next = st.count_zero ? crc32zs_pkg::S_FIN : crc32zs_pkg::S_SQR;
          end else begin
            ctl.data_step = 1'b1;
            if (st.is_last) begin
              state_next = crc32zs_pkg::S_PAD;
            end else begin
              ctl.out_load = 1'b1;
            end
          end
        end
      end
      crc32zs_pkg::S_PAD: begin
        ctl.pad_step = 1'b1;
        if (pad_end) begin
          ctl.out_load  = 1'b1;
          ctl.out_final = 1'b1;
          state_next    = crc32zs_pkg::S_IDLE;
        end
      end
      crc32zs_pkg::S_SQR: begin
        ctl.mul_step = 1'b1;
        if (idx_end) begin
          ctl.sqr_commit = 1'b1;
          if (st.rest_zero) begin
            state_next = crc32zs_pkg::S_FIN;
          end
        end
      end
      crc32zs_pkg::S_FIN: begin
        ctl.mul_step = 1'b1;
        ctl.mul_fin  = 1'b1;
        if (idx_end) begin
          ctl.fin_commit = 1'b1;
          ctl.out_load   = 1'b1;
          state_next     = crc32zs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = crc32zs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    idx_next = idx;
    if (ctl.shift_load) begin
      idx_next = '0;
    end else if (ctl.mul_step) begin
      idx_next = idx + 5'd1;
    end
    pad_idx_next = pad_idx;
    if (ctl.data_step) begin
      pad_idx_next = '0;
    end else if (ctl.pad_step) begin
      pad_idx_next = pad_idx + 2'd1;
    end
    out_valid_next = out_valid;
    if (ctl.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= crc32zs_pkg::S_IDLE;
      idx       <= '0;
      pad_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      pad_idx   <= pad_idx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/crc32zs_dp.sv
// Datapath with the CRC register, byte count, two serial GF(2) multipliers and the result register.
module crc32zs_dp #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 poly_we,
  input  logic [31:0]          poly_wdata,
  input  logic                 cmd,
  input  logic [7:0]           data_byte,
  input  logic                 first,
  input  logic                 last,
  input  logic [31:0]          zero_count,
  input  crc32zs_pkg::ctrl_t   ctl,
  output crc32zs_pkg::status_t st,
  output logic [31:0]          crc_value,
  output logic                 final_res
);

  logic [31:0]            poly;
  logic [31:0]            crc;
  logic [31:0]            crc_next;
  logic [2:0]             bytes_seen;
  logic [2:0]             bytes_seen_next;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_next;
  logic [31:0]            acc;
  logic [31:0]            acc_next;
  logic [31:0]            base;
  logic [31:0]            base_next;
  logic [31:0]            pa;
  logic [31:0]            pa_next;
  logic [31:0]            pb;
  logic [31:0]            pb_next;
  logic [31:0]            pa_step;
  logic [31:0]            pb_step;
  logic [31:0]            op_a;
  logic [31:0]            op_b;
  logic                   not_top;
  logic [31:0]            start_crc;
  logic [2:0]             start_seen;
  logic [7:0]             step_byte;
  logic [2:0]             pad_limit;

  assign st.is_shift   = (cmd == crc32zs_pkg::CMD_SHIFT);
  assign st.is_last    = last;
  assign st.count_zero = (zero_count[COUNT_WIDTH-1:0] == '0);
  assign st.rest_zero  = ((cnt >> 1) == '0);

  assign not_top = (ctl.mul_idx != crc32zs_pkg::MUL_STEP_LAST);
  assign op_a    = ctl.mul_fin ? crc : acc;
  assign op_b    = ctl.mul_fin ? acc : base;
  assign pa_step = crc32zs_pkg::gf_step(pa, op_a, op_b[ctl.mul_idx], not_top, poly);
  assign pb_step = crc32zs_pkg::gf_step(pb, base, base[ctl.mul_idx], not_top, poly);

  assign start_crc  = first ? 32'd0 : crc;
  assign start_seen = first ? 3'd0 : bytes_seen;
  assign step_byte  = (start_seen < crc32zs_pkg::BYTES_SAT)
                    ? (data_byte ^ crc32zs_pkg::BYTE_ONES) : data_byte;
  assign pad_limit  = {1'b0, crc32zs_pkg::PAD_STEP_LAST - ctl.pad_idx};

  always_comb begin
    crc_next        = crc;
    bytes_seen_next = bytes_seen;
    if (ctl.data_step) begin
      crc_next = crc32zs_pkg::div_step(start_crc, step_byte, poly);
      bytes_seen_next = (start_seen < crc32zs_pkg::BYTES_SAT) ? start_seen + 3'd1 : start_seen;
    end else if (ctl.pad_step) begin
      crc_next = crc32zs_pkg::div_step(crc, (bytes_seen <= pad_limit)
                                       ? crc32zs_pkg::BYTE_ONES : crc32zs_pkg::BYTE_ZERO, poly);
    end else if (ctl.fin_commit) begin
      crc_next = pa_step;
    end

    cnt_next  = cnt;
    acc_next  = acc;
    base_next = base;
    pa_next   = pa;
    pb_next   = pb;
    if (ctl.shift_load) begin
      cnt_next  = zero_count[COUNT_WIDTH-1:0];
      acc_next  = crc32zs_pkg::X_POW_0;
      base_next = crc32zs_pkg::X_POW_8;
      pa_next   = '0;
      pb_next   = '0;
    end else if (ctl.sqr_commit) begin
      cnt_next  = cnt >> 1;
      acc_next  = cnt[0] ? pa_step : acc;
      base_next = pb_step;
      pa_next   = '0;
      pb_next   = '0;
    end else if (ctl.fin_commit) begin
      pa_next = '0;
      pb_next = '0;
    end else if (ctl.mul_step) begin
      pa_next = pa_step;
      pb_next = pb_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly       <= crc32zs_pkg::POLY_RESET;
      crc        <= '0;
      bytes_seen <= '0;
    end else begin
      if (poly_we) begin
        poly <= poly_wdata;
      end
      crc        <= crc_next;
      bytes_seen <= bytes_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt  <= cnt_next;
    acc  <= acc_next;
    base <= base_next;
    pa   <= pa_next;
    pb   <= pb_next;
    if (ctl.out_load) begin
      crc_value <= ctl.out_final ? (crc_next ^ crc32zs_pkg::ALL_ONES) : crc_next;
      final_res <= ctl.out_final;
    end
  end

endmodule

>>> rtl/crc32_stream_with_zero_shift_unit.sv
// Top level of the reflected CRC-32 stream unit with zero-byte shift.
// A data byte that is not last has its result registered at the transfer edge.
// A last byte runs the byte step and four padding steps, one division step a cycle.
// A shift runs the bit-serial GF(2) multipliers, one product bit a cycle: a squaring pass
// per count bit up to the highest set one (none for a zero count), then a final multiply.
// Synchronous reset clears the CRC register and byte count and restores polynomial 0xEDB88320.
module crc32_stream_with_zero_shift_unit #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               poly_we,
  input  logic [31:0]        poly_wdata,
  crc32zs_in_if.sink         din,
  crc32zs_out_if.source      dout
);

  crc32zs_pkg::ctrl_t   ctl;
  crc32zs_pkg::status_t st;

  crc32zs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .st        (st),
    .ctl       (ctl)
  );

  crc32zs_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .poly_we    (poly_we),
    .poly_wdata (poly_wdata),
    .cmd        (din.cmd),
    .data_byte  (din.data_byte),
    .first      (din.first),
    .last       (din.last),
    .zero_count (din.zero_count),
    .ctl        (ctl),
    .st         (st),
    .crc_value  (dout.crc_value),
    .final_res  (dout.final_res)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!dout.valid || dout.ready))
    else $error("Result register loaded while a result is still pending.");

  a_final_from_pad: assert property (@(posedge clk) disable iff (rst)
    ctl.out_final |-> (ctl.pad_step && ctl.pad_idx == crc32zs_pkg::PAD_STEP_LAST))
    else $error("Finished CRC produced outside the last padding step.");

  a_shift_stalls: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && din.cmd == crc32zs_pkg::CMD_SHIFT) |=> !din.ready)
    else $error("Input taken while a shift is in progress.");

  a_single_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.data_step, ctl.shift_load, ctl.pad_step, ctl.mul_step}))
    else $error("More than one datapath operation commanded in a cycle.");

endmodule
